// File: hw/rtl/rvc_pkg.sv
// shared types and constants of the result vector cache
`timescale 1ns / 1ps
package rvc_pkg;

	localparam int DEF_SLOTS     = 256;
	localparam int DEF_MAX_ELEMS = 64;
	localparam int DEF_LAYERS    = 2;

	localparam logic OP_STORE    = 1'b0;
	localparam logic OP_RETRIEVE = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [63:0] lookup_key;
		logic        layer;
		logic [5:0]  position;
		logic [6:0]  list_length;
		logic [15:0] move_index;
		logic        has_index;
		logic [31:0] value_in;
		logic        first_of_store;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic        found;
		logic [31:0] value_out;
	} out_item_t;

	// classified item as it waits in the queue
	typedef struct packed {
		in_item_t   item;
		logic       layer_ok;
		logic       pos_ok;
		logic [6:0] count;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

endpackage

// File: hw/rtl/rvc_if.sv
// valid/ready channel interfaces of the result vector cache
`timescale 1ns / 1ps
interface rvc_in_if;
	logic               valid;
	logic               ready;
	rvc_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rvc_out_if;
	logic               valid;
	logic               ready;
	rvc_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/rvc_front.sv
// front end: accepts items, classifies them and queues them
`timescale 1ns / 1ps
module rvc_front #(
	parameter int MAX_ELEMS = rvc_pkg::DEF_MAX_ELEMS,
	parameter int LAYERS    = rvc_pkg::DEF_LAYERS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rvc_in_if.sink               in_ch,
	output rvc_pkg::queue_head_t head,
	input  logic                 pop
);
	rvc_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	rvc_pkg::cmd_t cmd;
	logic          push;
	logic          do_pop;

	// classification
	always_comb begin
		cmd.item     = in_ch.data;
		cmd.layer_ok = 32'(in_ch.data.layer) < LAYERS;
		cmd.pos_ok   = 32'(in_ch.data.position) < MAX_ELEMS;
		if (32'(in_ch.data.list_length) > MAX_ELEMS) begin
			cmd.count = 7'(MAX_ELEMS);
		end else begin
			cmd.count = in_ch.data.list_length;
		end
	end

	assign in_ch.ready = cnt_q != 2'd2;
	assign push        = in_ch.valid && in_ch.ready;
	assign do_pop      = pop && cnt_q != 2'd0;
	assign head.valid  = cnt_q != 2'd0;
	assign head.cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end
endmodule

// File: hw/rtl/rvc_back.sv
// back end: tag check, value store and index search with result register
`timescale 1ns / 1ps
module rvc_back #(
	parameter int SLOTS     = rvc_pkg::DEF_SLOTS,
	parameter int MAX_ELEMS = rvc_pkg::DEF_MAX_ELEMS,
	parameter int LAYERS    = rvc_pkg::DEF_LAYERS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rvc_pkg::queue_head_t head,
	output logic                 pop,
	rvc_out_if.source            out_ch
);
	localparam int SW    = $clog2(SLOTS);
	localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int EW    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int AW    = SW + LW + EW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_TAG  = 4'b0010,
		S_SRD  = 4'b0100,
		S_SCHK = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	rvc_pkg::cmd_t       cur_q;
	logic [63:0]         tag_mem [SLOTS];
	logic [SLOTS-1:0]    tag_vld_q;
	logic [63:0]         tag_rd_q;
	logic                tvld_rd_q;
	logic [31:0]         val_mem [DEPTH];
	logic [15:0]         idx_mem [DEPTH];
	logic [31:0]         val_rd_q;
	logic [15:0]         idx_rd_q;
	logic                writing_q;
	logic [6:0]          j_q;
	logic                out_vq;
	rvc_pkg::out_item_t  out_data_q;

	logic [SW-1:0]       head_slot, cur_slot;
	logic                tag_eq, new_wr, is_retr, idx_eq, out_free;
	logic                rd_en, tag_we, val_we, idx_we;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic                emit;
	rvc_pkg::out_item_t  res;
	logic                j_inc, j_clr;

	assign head_slot = head.cmd.item.lookup_key[SW-1:0];
	assign cur_slot  = cur_q.item.lookup_key[SW-1:0];
	assign tag_eq    = tvld_rd_q ? (tag_rd_q == cur_q.item.lookup_key)
	                             : (cur_q.item.lookup_key == 64'd0);
	assign is_retr   = cur_q.item.opcode == rvc_pkg::OP_RETRIEVE;
	assign new_wr    = cur_q.item.first_of_store ? !tag_eq : writing_q;
	assign idx_eq    = idx_rd_q == cur_q.item.move_index;
	assign out_free  = !out_vq || out_ch.ready;
	assign wr_addr   = {cur_slot, LW'(cur_q.item.layer), EW'(cur_q.item.position)};

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = {head_slot, LW'(head.cmd.item.layer), EW'(head.cmd.item.position)};
		tag_we  = 1'b0;
		val_we  = 1'b0;
		idx_we  = 1'b0;
		emit    = 1'b0;
		res     = '0;
		j_inc   = 1'b0;
		j_clr   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					pop     = 1'b1;
					rd_en   = 1'b1;
					state_d = S_TAG;
				end
			end
			S_TAG: begin
				if (!is_retr) begin
					tag_we  = cur_q.item.first_of_store && !tag_eq;
					val_we  = new_wr && cur_q.layer_ok && cur_q.pos_ok;
					idx_we  = val_we && cur_q.item.has_index;
					state_d = S_IDLE;
				end else begin
					res.hit = tag_eq;
					if (!tag_eq || !cur_q.layer_ok) begin
						emit = 1'b1;
					end else if (!cur_q.item.has_index) begin
						emit          = 1'b1;
						res.found     = cur_q.pos_ok;
						res.value_out = cur_q.pos_ok ? val_rd_q : 32'd0;
					end else if (cur_q.pos_ok && idx_eq) begin
						emit          = 1'b1;
						res.found     = 1'b1;
						res.value_out = val_rd_q;
					end else if (cur_q.count == 7'd0) begin
						emit = 1'b1;
					end else begin
						j_clr   = 1'b1;
						state_d = S_SRD;
					end
					if (emit && out_free) begin
						state_d = S_IDLE;
					end else if (emit) begin
						emit    = 1'b0;
					end
				end
			end
			S_SRD: begin
				rd_en   = 1'b1;
				rd_addr = {cur_slot, LW'(cur_q.item.layer), EW'(j_q)};
				state_d = S_SCHK;
			end
			S_SCHK: begin
				res.hit = 1'b1;
				if (idx_eq) begin
					res.found     = 1'b1;
					res.value_out = val_rd_q;
					if (out_free) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else if ((j_q + 7'd1) == cur_q.count) begin
					if (out_free) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					j_inc   = 1'b1;
					state_d = S_SRD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q    <= head.cmd;
			tag_rd_q <= tag_mem[head_slot];
		end
		if (tag_we) begin
			tag_mem[cur_slot] <= cur_q.item.lookup_key;
		end
		if (rd_en) begin
			val_rd_q <= val_mem[rd_addr];
			idx_rd_q <= idx_mem[rd_addr];
		end
		if (val_we) begin
			val_mem[wr_addr] <= cur_q.item.value_in;
		end
		if (idx_we) begin
			idx_mem[wr_addr] <= cur_q.item.move_index;
		end
		if (emit) begin
			out_data_q <= res;
		end
		if (j_clr) begin
			j_q <= 7'd0;
		end else if (j_inc) begin
			j_q <= j_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tag_vld_q <= '0;
			tvld_rd_q <= 1'b0;
			writing_q <= 1'b0;
			out_vq    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				tvld_rd_q <= tag_vld_q[head_slot];
			end
			if (tag_we) begin
				tag_vld_q[cur_slot] <= 1'b1;
			end
			if (state_q == S_TAG && !is_retr) begin
				writing_q <= new_wr;
			end
			if (emit) begin
				out_vq <= 1'b1;
			end else if (out_ch.ready) begin
				out_vq <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_vq;
	assign out_ch.data  = out_data_q;
endmodule

// File: hw/rtl/result_vector_cache_core.sv
// top level of the result vector cache
`timescale 1ns / 1ps
// direct-mapped cache of result lists keyed by a 64-bit hash
// in_ch: store and retrieve items, valid/ready, taken when both are high
// out_ch: one result item (hit, found, value_out) per retrieve, none per store
// the slot is the low log2(SLOTS) bits of the key, SLOTS a power of two
// front end classifies items into a two-entry queue, back end executes them
// a store or a retrieve found at its own position passes the back end through its idle and tag states
// a retrieve whose index misses at its position walks the stored indices,
// reading and then checking each entry over up to min(list_length, MAX_ELEMS) entries,
// bound by the single read port of the value/index memory
// from acceptance a result passes three registers at best (queue, tag read, result)
// reset clears the tag valid bits, so every tag reads as zero; no clearing pass
// value and index memories hold nothing defined until written
// a stalled receiver holds the result register; the back end waits with the
// next result and the queue keeps accepting until its two entries are full
module result_vector_cache_core #(
	parameter int SLOTS     = rvc_pkg::DEF_SLOTS,
	parameter int MAX_ELEMS = rvc_pkg::DEF_MAX_ELEMS,
	parameter int LAYERS    = rvc_pkg::DEF_LAYERS
) (
	input  logic      clk,
	input  logic      arst_n,
	rvc_in_if.sink    in_ch,
	rvc_out_if.source out_ch
);
	// queue head from the front end, pop from the back end
	rvc_pkg::queue_head_t head;
	logic                 pop;

	rvc_front #(
		.MAX_ELEMS (MAX_ELEMS),
		.LAYERS    (LAYERS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.head   (head),
		.pop    (pop)
	);

	rvc_back #(
		.SLOTS     (SLOTS),
		.MAX_ELEMS (MAX_ELEMS),
		.LAYERS    (LAYERS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// the back end only takes an item that the queue holds
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");

	// an accepted item is in the queue on the next cycle
	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> head.valid) else $error("item lost in queue");

	// the back end works on one item at a time and never pops back to back
	a_pop_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !pop) else $error("back to back pop");
endmodule

// File: verif/rvc_checker.sv
// checker of the result vector cache: watches both channels, predicts and compares results
`timescale 1ns / 1ps
module rvc_checker #(
	parameter int SLOTS     = rvc_pkg::DEF_SLOTS,
	parameter int MAX_ELEMS = rvc_pkg::DEF_MAX_ELEMS,
	parameter int LAYERS    = rvc_pkg::DEF_LAYERS
) (
	input  logic clk,
	input  logic arst_n,
	rvc_in_if    in_mon,
	rvc_out_if   out_mon,
	output int   fail_count,
	output int   pending
);
	import rvc_pkg::*;

	localparam int DEPTH = SLOTS * LAYERS * MAX_ELEMS;

	logic [63:0] tag_mem [SLOTS];
	logic [31:0] val_mem [DEPTH];
	logic [15:0] idx_mem [DEPTH];
	logic        writing;
	out_item_t   lookup_q[$];

	function automatic int word_at(int slot, int layer, int pos);
		return (slot * LAYERS + layer) * MAX_ELEMS + pos;
	endfunction

	// update the cache copy with one accepted item, queue the lookup result if any
	function automatic void cache_apply(in_item_t it);
		int        slot;
		int        n;
		int        a;
		bit        layer_ok;
		bit        pos_ok;
		out_item_t r;
		slot     = int'(it.lookup_key % SLOTS);
		layer_ok = it.layer < LAYERS;
		pos_ok   = it.position < MAX_ELEMS;
		if (it.opcode == OP_STORE) begin
			if (it.first_of_store) begin
				writing = tag_mem[slot] != it.lookup_key;
				tag_mem[slot] = it.lookup_key;
			end
			if (writing && layer_ok && pos_ok) begin
				a = word_at(slot, it.layer, it.position);
				val_mem[a] = it.value_in;
				if (it.has_index)
					idx_mem[a] = it.move_index;
			end
			return;
		end
		r = '0;
		r.hit = tag_mem[slot] == it.lookup_key;
		if (r.hit && layer_ok) begin
			a = word_at(slot, it.layer, it.position);
			if (!it.has_index) begin
				if (pos_ok) begin
					r.found = 1'b1;
					r.value_out = val_mem[a];
				end
			end else if (pos_ok && idx_mem[a] == it.move_index) begin
				r.found = 1'b1;
				r.value_out = val_mem[a];
			end else begin
				n = (it.list_length > MAX_ELEMS) ? MAX_ELEMS : int'(it.list_length);
				for (int j = 0; j < n; j++) begin
					a = word_at(slot, it.layer, j);
					if (idx_mem[a] == it.move_index) begin
						r.found = 1'b1;
						r.value_out = val_mem[a];
						break;
					end
				end
			end
		end
		lookup_q.insert(lookup_q.size(), r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				tag_mem[s] = '0;
			writing = 1'b0;
			lookup_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (lookup_q.size() == 0) begin
					$display("%0t: unexpected result item, actual %p", $time, out_mon.data);
					fail_count++;
				end else begin
					e = lookup_q.pop_front();
					if (out_mon.data.hit !== e.hit) begin
						$display("%0t: hit mismatch, expected %0b actual %0b",
							$time, e.hit, out_mon.data.hit);
						fail_count++;
					end
					if (out_mon.data.found !== e.found) begin
						$display("%0t: found mismatch, expected %0b actual %0b",
							$time, e.found, out_mon.data.found);
						fail_count++;
					end
					if (out_mon.data.value_out !== e.value_out) begin
						$display("%0t: value_out mismatch, expected %h actual %h",
							$time, e.value_out, out_mon.data.value_out);
						fail_count++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				cache_apply(in_mon.data);
			pending = lookup_q.size();
		end
	end

endmodule

// File: verif/result_vector_cache_core_tb.sv
// testbench top of the result vector cache: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module result_vector_cache_core_tb;
	import rvc_pkg::*;

	localparam int SLOTS     = DEF_SLOTS;
	localparam int MAX_ELEMS = DEF_MAX_ELEMS;
	localparam int LAYERS    = DEF_LAYERS;
	localparam int DEPTH     = SLOTS * LAYERS * MAX_ELEMS;
	localparam int N_ITEMS   = 1900;
	localparam int CALM_FROM = 1700;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   n_sent;
	bit   calm;

	rvc_in_if  in_ch ();
	rvc_out_if out_ch ();

	result_vector_cache_core #(
		.SLOTS(SLOTS), .MAX_ELEMS(MAX_ELEMS), .LAYERS(LAYERS)
	) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	rvc_checker #(
		.SLOTS(SLOTS), .MAX_ELEMS(MAX_ELEMS), .LAYERS(LAYERS)
	) u_checker (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .pending(pending)
	);

	// stimulus-side shadow of tags and of which entries hold defined data,
	// so that no retrieve ever reads an entry never written since reset
	logic [63:0] sh_tag [SLOTS];
	logic [15:0] sh_idx [DEPTH];
	bit          sh_val_ok [DEPTH];
	bit          sh_idx_ok [DEPTH];
	bit          sh_writing;

	// key pool: few slots shared by several keys, so hits and evictions are frequent
	logic [63:0] key_pool [16];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int word_at(logic [63:0] key, logic layer, logic [5:0] pos);
		return (int'(key % SLOTS) * LAYERS + int'(layer)) * MAX_ELEMS + int'(pos);
	endfunction

	function automatic in_item_t mk(logic op, logic [63:0] key, logic layer,
			logic [5:0] pos, logic [6:0] len, logic [15:0] mi, logic hi,
			logic [31:0] val, logic first);
		in_item_t it;
		it.opcode = op;
		it.lookup_key = key;
		it.layer = layer;
		it.position = pos;
		it.list_length = len;
		it.move_index = mi;
		it.has_index = hi;
		it.value_in = val;
		it.first_of_store = first;
		return it;
	endfunction

	// a retrieve that would touch an undefined entry is turned into a miss
	// on the same slot by flipping the top bit of the stored tag
	function automatic in_item_t make_safe(in_item_t it);
		int slot;
		int a;
		int n;
		bit ok;
		slot = int'(it.lookup_key % SLOTS);
		if (it.opcode != OP_RETRIEVE || sh_tag[slot] != it.lookup_key || it.layer >= LAYERS)
			return it;
		a = word_at(it.lookup_key, it.layer, it.position);
		if (!it.has_index)
			ok = sh_val_ok[a];
		else if (sh_idx_ok[a] && sh_idx[a] == it.move_index)
			ok = 1'b1;
		else if (!sh_idx_ok[a])
			ok = 1'b0;
		else begin
			ok = 1'b1;
			n = (it.list_length > MAX_ELEMS) ? MAX_ELEMS : int'(it.list_length);
			for (int j = 0; j < n; j++) begin
				a = word_at(it.lookup_key, it.layer, 6'(j));
				if (!sh_idx_ok[a]) begin
					ok = 1'b0;
					break;
				end
				if (sh_idx[a] == it.move_index)
					break;
			end
		end
		if (!ok)
			it.lookup_key = sh_tag[slot] ^ 64'h8000_0000_0000_0000;
		return it;
	endfunction

	function automatic void shadow_store(in_item_t it);
		int slot;
		int a;
		if (it.opcode != OP_STORE)
			return;
		slot = int'(it.lookup_key % SLOTS);
		if (it.first_of_store) begin
			sh_writing = sh_tag[slot] != it.lookup_key;
			sh_tag[slot] = it.lookup_key;
		end
		if (sh_writing && it.layer < LAYERS) begin
			a = word_at(it.lookup_key, it.layer, it.position);
			sh_val_ok[a] = 1'b1;
			if (it.has_index) begin
				sh_idx_ok[a] = 1'b1;
				sh_idx[a] = it.move_index;
			end
		end
	endfunction

	// drive one item from a falling edge, hold it until taken, return at a falling edge
	task automatic send_item(in_item_t raw);
		in_item_t it;
		it = make_safe(raw);
		in_ch.valid <= 1'b1;
		in_ch.data  <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		shadow_store(it);
		n_sent++;
		calm = n_sent >= CALM_FROM;
		// sender gap burst
		if (!calm && $urandom_range(7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	function automatic logic [15:0] pick_index();
		return ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
	endfunction

	function automatic logic [6:0] pick_length();
		case ($urandom_range(9))
			0: return 7'($urandom_range(0, 127));
			1: return 7'd64;
			default: return 7'($urandom_range(1, 8));
		endcase
	endfunction

	// one store call: first element takes the slot, the rest follow in order;
	// now and then the first mark is dropped or the order shuffled
	task automatic store_call();
		logic [63:0] key;
		logic        layer;
		logic        hi;
		int          len;
		int          mode;
		int          pos;
		key   = key_pool[$urandom_range(0, 15)];
		layer = 1'($urandom);
		hi    = $urandom_range(4) != 0;
		len   = ($urandom_range(15) == 0) ? MAX_ELEMS : $urandom_range(1, 8);
		mode  = $urandom_range(9);
		for (int p = 0; p < len; p++) begin
			pos = (mode == 1) ? $urandom_range(0, len - 1) : p;
			send_item(mk(OP_STORE, key, layer, 6'(pos), 7'(len), pick_index(), hi,
				$urandom, (mode != 0) && (p == 0)));
		end
	endtask

	task automatic retrieve_burst();
		logic [63:0] key;
		logic [5:0]  pos;
		repeat ($urandom_range(1, 6)) begin
			key = ($urandom_range(7) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 15)];
			pos = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
			send_item(mk(OP_RETRIEVE, key, 1'($urandom), pos, pick_length(), pick_index(),
				1'($urandom_range(3) != 0), $urandom, 1'($urandom)));
		end
	endtask

	// receiver stall bursts
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else
				out_ch.ready <= 1'b1;
		end
	end

	initial begin
		logic [63:0] k_top;
		logic [63:0] k_rival;
		int          wait_cycles;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		arst_n      = 1'b0;
		n_sent      = 0;
		calm        = 1'b0;
		sh_writing  = 1'b0;
		for (int s = 0; s < SLOTS; s++)
			sh_tag[s] = '0;
		for (int a = 0; a < DEPTH; a++) begin
			sh_val_ok[a] = 1'b0;
			sh_idx_ok[a] = 1'b0;
			sh_idx[a] = '0;
		end
		for (int i = 0; i < 16; i++)
			key_pool[i] = {$urandom, 24'($urandom), 8'(i % 6 * 41 + 3)};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		k_top   = 64'hFFFF_FFFF_FFFF_FFFF;
		k_rival = 64'h7FFF_0000_0000_00FF;
		// miss right after reset, then a store element with no first: writes nothing
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd0, 7'd1, 16'd0, 1'b0, 32'd0, 1'b0));
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd0, 7'd4, 16'd5, 1'b1, 32'h1234_5678, 1'b0));
		// a four-element indexed list at the extremes of the value and index ranges, plus one at the last position
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd0, 7'd4, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd1, 7'd4, 16'h0000, 1'b1, 32'h0000_0000, 1'b0));
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd2, 7'd4, 16'h00A5, 1'b1, 32'h8000_0001, 1'b0));
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd3, 7'd4, 16'h5A00, 1'b1, 32'h7FFF_FFFE, 1'b0));
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd63, 7'd64, 16'h0007, 1'b1, 32'hCAFE_0063, 1'b0));
		// by position, by matching index, by index search, search that finds nothing
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd1, 7'd4, 16'd0, 1'b0, 32'd0, 1'b0));
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd63, 7'd64, 16'd0, 1'b0, 32'd0, 1'b0));
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd2, 7'd4, 16'h00A5, 1'b1, 32'd0, 1'b0));
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd3, 7'd4, 16'hFFFF, 1'b1, 32'd0, 1'b0));
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd0, 7'd4, 16'h1111, 1'b1, 32'd0, 1'b0));
		// zero-length list: no search at all
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd0, 7'd0, 16'h0000, 1'b1, 32'd0, 1'b0));
		// other layer of the same entry never written
		send_item(mk(OP_RETRIEVE, k_top, 1'b0, 6'd0, 7'd1, 16'd0, 1'b0, 32'd0, 1'b0));
		// repeat store of the same key: tag matches, the whole store is dropped
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd1, 7'd4, 16'h0000, 1'b1, 32'hDEAD_BEEF, 1'b1));
		send_item(mk(OP_STORE, k_top, 1'b1, 6'd2, 7'd4, 16'h00A5, 1'b1, 32'hDEAD_BEEF, 1'b0));
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd1, 7'd4, 16'd0, 1'b0, 32'd0, 1'b0));
		// a rival key on the same slot evicts, the old key now misses
		send_item(mk(OP_STORE, k_rival, 1'b0, 6'd0, 7'd1, 16'h0001, 1'b0, 32'h0BAD_F00D, 1'b1));
		send_item(mk(OP_RETRIEVE, k_top, 1'b1, 6'd1, 7'd4, 16'd0, 1'b0, 32'd0, 1'b0));
		send_item(mk(OP_RETRIEVE, k_rival, 1'b0, 6'd0, 7'd1, 16'd0, 1'b0, 32'd0, 1'b0));
		// key zero against the reset tag: store dropped, retrieve kept safe
		send_item(mk(OP_STORE, 64'd0, 1'b0, 6'd0, 7'd1, 16'd0, 1'b1, 32'h1, 1'b1));
		send_item(mk(OP_RETRIEVE, 64'd0, 1'b0, 6'd0, 7'd1, 16'd0, 1'b0, 32'd0, 1'b0));

		// random part: mostly well-formed store calls and retrieves, some noise
		while (n_sent < N_ITEMS) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: store_call();
				9, 10, 11, 12, 13, 14, 15, 16: retrieve_burst();
				17: key_pool[$urandom_range(0, 15)] = {$urandom, $urandom};
				default: send_item({1'($urandom), $urandom, $urandom, 1'($urandom),
					6'($urandom), 7'($urandom), 16'($urandom), 1'($urandom),
					32'($urandom), 1'($urandom)});
			endcase
		end
		in_ch.valid <= 1'b0;

		// drain, then wait in case a stray result shows up
		while (pending != 0)
			@(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < 200) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
